[hw/rtl/vsp_pkg.sv]
// Shared types, constants and sizes for the VGA scan-out with pixel doubling.
`default_nettype none

package vsp_pkg;

   // Frame store geometry
   localparam int FB_WIDTH  = 320;
   localparam int FB_HEIGHT = 200;
   localparam int FB_DEPTH  = FB_WIDTH * FB_HEIGHT;
   localparam int FB_ADDR_W = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;
   localparam int PROD_W    = FB_ADDR_W + 10;

   // Raster timing
   localparam int LINE_PIXELS   = 800;
   localparam int TOTAL_LINES   = 525;
   localparam int VISIBLE_LINES = 480;
   localparam int HSYNC_COLS    = 96;
   localparam int PICTURE_START = LINE_PIXELS - 656;
   localparam int PICTURE_COLS  = 640;
   localparam int VSYNC_FIRST   = 490;
   localparam int VSYNC_LAST    = 491;
   localparam int COL_W         = 10;
   localparam int LINE_W        = 10;
   localparam int ACC_W         = 10;

   // Pin byte codes, syncs active low
   localparam logic [7:0] PIN_IDLE   = 8'hC0;
   localparam logic [7:0] PIN_HSYNC  = 8'h80;
   localparam logic [7:0] PIN_VSYNC  = 8'h40;
   localparam logic [7:0] PIN_HVSYNC = 8'h00;
   localparam logic [7:0] COLOR_MASK = 8'h3F;
   localparam int         COLOR_W    = 6;

   // Input function codes
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic {
      KIND_TICK  = 1'b0,
      KIND_WRITE = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type          kind;
      logic [FB_ADDR_W-1:0]   addr;
      logic [COLOR_W-1:0]     color;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

`default_nettype wire

[hw/rtl/vsp_front.sv]
// Front end: takes input transfers, drops out-of-range writes, forms queue entries.
`default_nettype none

module vsp_front (
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_func,
   input  wire logic [8:0]                req_pixel_x,
   input  wire logic [7:0]                req_pixel_y,
   input  wire logic [7:0]                req_pixel_color,
   input  wire vsp_pkg::queue_status_type q_status,
   input  wire vsp_pkg::back_status_type  back_status,
   output logic                           q_push,
   output vsp_pkg::queue_entry_type       q_push_entry
);

   logic                       accept;
   logic                       in_range;
   logic [vsp_pkg::PROD_W-1:0] wr_addr;

   // Hold the requester while the store is being cleared or the queue is full
   assign req_stall = q_status.full || back_status.clearing;
   assign accept    = req_valid && !req_stall;

   // Classify write coordinates and form the linear store address
   assign in_range = ({1'b0, req_pixel_x} < 10'(vsp_pkg::FB_WIDTH)) &&
                     ({1'b0, req_pixel_y} < 9'(vsp_pkg::FB_HEIGHT));
   assign wr_addr  = vsp_pkg::PROD_W'(req_pixel_y) * vsp_pkg::PROD_W'(vsp_pkg::FB_WIDTH) +
                     vsp_pkg::PROD_W'(req_pixel_x);

   // Drop out-of-range writes; everything else goes to the back end
   always_comb begin
      q_push             = 1'b0;
      q_push_entry.kind  = vsp_pkg::KIND_TICK;
      q_push_entry.addr  = wr_addr[vsp_pkg::FB_ADDR_W-1:0];
      q_push_entry.color = req_pixel_color[vsp_pkg::COLOR_W-1:0];
      if (req_func == vsp_pkg::FUNC_WRITE) begin
         q_push_entry.kind = vsp_pkg::KIND_WRITE;
         q_push            = accept && in_range;
      end else begin
         q_push = accept;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/vsp_queue.sv]
// Short command queue between the front end and the back end.
`default_nettype none

module vsp_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire vsp_pkg::queue_entry_type  push_entry,
   input  wire logic                      pop,
   output vsp_pkg::queue_entry_type       pop_entry,
   output vsp_pkg::queue_status_type      status
);

   vsp_pkg::queue_entry_type           entries_ff [vsp_pkg::QUEUE_DEPTH];
   logic [vsp_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [vsp_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [vsp_pkg::QUEUE_PTR_W:0]      count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign status.full  = (count_ff == (vsp_pkg::QUEUE_PTR_W+1)'(vsp_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_entry    = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == vsp_pkg::QUEUE_PTR_W'(vsp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == vsp_pkg::QUEUE_PTR_W'(vsp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/vsp_back.sv]
// Back end: raster counters, frame store, pixel lookup and output register.
`default_nettype none

module vsp_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire vsp_pkg::queue_status_type q_status,
   input  wire vsp_pkg::queue_entry_type  q_entry,
   output logic                           q_pop,
   output vsp_pkg::back_status_type       status,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [7:0]                     rsp_pin_byte,
   output logic                           rsp_active_video,
   output logic [31:0]                    rsp_frames_done
);

   // Frame store
   logic [vsp_pkg::COLOR_W-1:0]   mem [vsp_pkg::FB_DEPTH];
   logic                          mem_we;
   logic [vsp_pkg::FB_ADDR_W-1:0] mem_waddr;
   logic [vsp_pkg::COLOR_W-1:0]   mem_wdata;
   logic                          mem_re;
   logic [vsp_pkg::FB_ADDR_W-1:0] mem_raddr;
   logic [vsp_pkg::COLOR_W-1:0]   rd_data_ff;

   // Clearing pass
   logic                          clearing_ff, clearing_in;
   logic [vsp_pkg::FB_ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // Raster state
   logic [vsp_pkg::COL_W-1:0]     col_ff, col_in;
   logic [vsp_pkg::LINE_W-1:0]    line_ff, line_in;
   logic [31:0]                   frame_ff, frame_in;
   logic [vsp_pkg::ACC_W-1:0]     vacc_ff, vacc_in;
   logic [vsp_pkg::FB_ADDR_W-1:0] row_base_ff, row_base_in;

   // Lookup stage and output register
   logic                          s1_vld_ff, s1_vld_in;
   logic [7:0]                    s1_sync_ff;
   logic                          s1_active_ff;
   logic                          s1_use_pix_ff;
   logic [31:0]                   s1_frames_ff;
   logic                          out_vld_ff, out_vld_in;
   logic [7:0]                    out_pin_ff;
   logic                          out_active_ff;
   logic [31:0]                   out_frames_ff;

   // Combinational helpers
   logic                          out_can;
   logic                          out_load;
   logic                          s1_can_load;
   logic                          pop_tick;
   logic                          pop_write;
   logic                          hs;
   logic                          vis_line;
   logic                          vs;
   logic                          in_picture;
   logic [vsp_pkg::COL_W-1:0]     col_off;
   logic [vsp_pkg::COL_W-1:0]     sx;
   logic                          sx_in_row;
   logic [7:0]                    sync_byte;
   logic [vsp_pkg::ACC_W:0]       vacc_sum;
   logic [vsp_pkg::COLOR_W-1:0]   pix;

   assign status.clearing = clearing_ff;

   // Pipeline flow control
   assign out_can     = !out_vld_ff || !rsp_stall;
   assign out_load    = s1_vld_ff && out_can;
   assign s1_can_load = !s1_vld_ff || out_can;

   // Unless clearing, pop any write at the head, a tick when the lookup stage frees up
   always_comb begin
      q_pop = 1'b0;
      if (!q_status.empty && !clearing_ff) begin
         if (q_entry.kind == vsp_pkg::KIND_WRITE) begin
            q_pop = 1'b1;
         end else begin
            q_pop = s1_can_load;
         end
      end
   end
   assign pop_tick  = q_pop && (q_entry.kind == vsp_pkg::KIND_TICK);
   assign pop_write = q_pop && (q_entry.kind == vsp_pkg::KIND_WRITE);

   // Classify the current raster position
   assign hs         = col_ff < vsp_pkg::COL_W'(vsp_pkg::HSYNC_COLS);
   assign vis_line   = line_ff < vsp_pkg::LINE_W'(vsp_pkg::VISIBLE_LINES);
   assign vs         = (line_ff == vsp_pkg::LINE_W'(vsp_pkg::VSYNC_FIRST)) ||
                       (line_ff == vsp_pkg::LINE_W'(vsp_pkg::VSYNC_LAST));
   assign in_picture = vis_line && !hs &&
                       (col_ff >= vsp_pkg::COL_W'(vsp_pkg::PICTURE_START)) &&
                       (col_ff < vsp_pkg::COL_W'(vsp_pkg::PICTURE_START +
                                                 vsp_pkg::PICTURE_COLS));
   assign col_off    = col_ff - vsp_pkg::COL_W'(vsp_pkg::PICTURE_START);
   assign sx         = {1'b0, col_off[vsp_pkg::COL_W-1:1]};
   assign sx_in_row  = sx < vsp_pkg::COL_W'(vsp_pkg::FB_WIDTH);

   // Select the sync pattern
   always_comb begin
      if (!vis_line) begin
         if (vs) begin
            sync_byte = hs ? vsp_pkg::PIN_HVSYNC : vsp_pkg::PIN_VSYNC;
         end else begin
            sync_byte = hs ? vsp_pkg::PIN_HSYNC : vsp_pkg::PIN_IDLE;
         end
      end else if (hs) begin
         sync_byte = vsp_pkg::PIN_HSYNC;
      end else begin
         sync_byte = vsp_pkg::PIN_IDLE;
      end
   end

   // Advance column, line, frame and the store row tracker on each tick
   assign vacc_sum = {1'b0, vacc_ff} + (vsp_pkg::ACC_W+1)'(vsp_pkg::FB_HEIGHT);

   always_comb begin
      col_in      = col_ff;
      line_in     = line_ff;
      frame_in    = frame_ff;
      vacc_in     = vacc_ff;
      row_base_in = row_base_ff;
      if (pop_tick) begin
         if (col_ff == vsp_pkg::COL_W'(vsp_pkg::LINE_PIXELS - 1)) begin
            col_in = '0;
            if (line_ff == vsp_pkg::LINE_W'(vsp_pkg::TOTAL_LINES - 1)) begin
               line_in     = '0;
               frame_in    = frame_ff + 32'd1;
               vacc_in     = '0;
               row_base_in = '0;
            end else begin
               line_in = line_ff + 1'b1;
               if (line_ff < vsp_pkg::LINE_W'(vsp_pkg::VISIBLE_LINES - 1)) begin
                  if (vacc_sum >= (vsp_pkg::ACC_W+1)'(vsp_pkg::VISIBLE_LINES)) begin
                     vacc_in     = vsp_pkg::ACC_W'(vacc_sum -
                                   (vsp_pkg::ACC_W+1)'(vsp_pkg::VISIBLE_LINES));
                     row_base_in = row_base_ff + vsp_pkg::FB_ADDR_W'(vsp_pkg::FB_WIDTH);
                  end else begin
                     vacc_in = vacc_sum[vsp_pkg::ACC_W-1:0];
                  end
               end
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // Sweep the store after reset
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == vsp_pkg::FB_ADDR_W'(vsp_pkg::FB_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // Store port selection
   assign mem_we    = clearing_ff || pop_write;
   assign mem_waddr = clearing_ff ? clr_addr_ff : q_entry.addr;
   assign mem_wdata = clearing_ff ? '0 : q_entry.color;
   assign mem_re    = pop_tick;
   assign mem_raddr = row_base_ff + vsp_pkg::FB_ADDR_W'(sx);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // Pipeline valids
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (pop_tick) begin
         s1_vld_in = 1'b1;
      end else if (out_load) begin
         s1_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         col_ff      <= '0;
         line_ff     <= '0;
         frame_ff    <= '0;
         vacc_ff     <= '0;
         row_base_ff <= '0;
         s1_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
         col_ff      <= col_in;
         line_ff     <= line_in;
         frame_ff    <= frame_in;
         vacc_ff     <= vacc_in;
         row_base_ff <= row_base_in;
         s1_vld_ff   <= s1_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // Capture tick attributes alongside the store read
   always_ff @(posedge clock) begin
      if (pop_tick) begin
         s1_sync_ff    <= sync_byte;
         s1_active_ff  <= in_picture;
         s1_use_pix_ff <= in_picture && sx_in_row;
         s1_frames_ff  <= frame_in;
      end
   end

   // Merge pixel colour and load the output register
   assign pix = s1_use_pix_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_pin_ff    <= s1_sync_ff | (8'(pix) & vsp_pkg::COLOR_MASK);
         out_active_ff <= s1_active_ff;
         out_frames_ff <= s1_frames_ff;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_pin_byte     = out_pin_ff;
   assign rsp_active_video = out_active_ff;
   assign rsp_frames_done  = out_frames_ff;

endmodule

`default_nettype wire

[hw/rtl/vga_scan_out_with_pixel_doubling_core.sv]
// A tick's result goes through the queue, the lookup stage and the output register.
// Throughput: one item per cycle unless clearing or rsp_stall holds back the ticks;
//   the store has one write and one read port, and each queued item uses one of them.
// Writes give no result; a taken write passes through the queue and lands in the store.
// Reset: synchronous; counters clear at once, then a clearing pass over 64000 entries
//   blacks the frame store, one entry a cycle, with req_stall held high throughout.
`default_nettype none

module vga_scan_out_with_pixel_doubling_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [8:0]  req_pixel_x,
   input  wire logic [7:0]  req_pixel_y,
   input  wire logic [7:0]  req_pixel_color,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_pin_byte,
   output logic             rsp_active_video,
   output logic [31:0]      rsp_frames_done
);

   vsp_pkg::queue_status_type q_status;
   vsp_pkg::back_status_type  back_status;
   vsp_pkg::queue_entry_type  q_push_entry;
   vsp_pkg::queue_entry_type  q_pop_entry;
   logic                      q_push;
   logic                      q_pop;

   // Accept and classify
   vsp_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_pixel_color (req_pixel_color),
      .q_status        (q_status),
      .back_status     (back_status),
      .q_push          (q_push),
      .q_push_entry    (q_push_entry)
   );

   // Decouple front and back
   vsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry),
      .status     (q_status)
   );

   // Scan out and store writes
   vsp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_entry          (q_pop_entry),
      .q_pop            (q_pop),
      .status           (back_status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pin_byte     (rsp_pin_byte),
      .rsp_active_video (rsp_active_video),
      .rsp_frames_done  (rsp_frames_done)
   );

endmodule

`default_nettype wire

[hw/rtl/vsp_checker.sv]
// Port-level checks for the scan-out core, bound to the top level.
`default_nettype none

module vsp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_func,
   input wire logic [8:0]  req_pixel_x,
   input wire logic [7:0]  req_pixel_y,
   input wire logic [7:0]  req_pixel_color,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_pin_byte,
   input wire logic        rsp_active_video,
   input wire logic [31:0] rsp_frames_done
);

   // The store sweep holds off input right after reset
   a_stall_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("input not held off after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pin_byte) &&
                                 $stable(rsp_active_video) && $stable(rsp_frames_done))
      else $error("stalled result changed");

   // Picture area carries no sync
   a_active_no_sync: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_active_video |-> rsp_pin_byte[7:6] == 2'b11)
      else $error("sync asserted in picture area");

   // Blanking carries no colour
   a_blank_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active_video |-> rsp_pin_byte[5:0] == 6'd0)
      else $error("colour outside picture area");

endmodule

bind vga_scan_out_with_pixel_doubling_core vsp_checker u_vsp_checker (.*);

`default_nettype wire

[sim/tb_vga_scan_out_with_pixel_doubling_core.sv]
// Self-checking testbench for the VGA scan-out core with pixel doubling.
`default_nettype none

module tb_vga_scan_out_with_pixel_doubling_core;

   // One scanned-out pixel as it leaves the rsp_ side
   typedef struct packed {
      logic [7:0]  pin_byte;
      logic        active_video;
      logic [31:0] frames_done;
   } scan_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = vsp_pkg::FUNC_TICK;
   logic [8:0]  req_pixel_x = '0;
   logic [7:0]  req_pixel_y = '0;
   logic [7:0]  req_pixel_color = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_pin_byte;
   logic        rsp_active_video;
   logic [31:0] rsp_frames_done;

   // Raster position, frame count and frame store as the block should hold them
   int                          col_pos = 0;
   int                          line_pos = 0;
   logic [31:0]                 frames_model = '0;
   logic [vsp_pkg::COLOR_W-1:0] fb_model [vsp_pkg::FB_DEPTH];

   scan_out_type pending_scan_out[$];
   int           mismatch_count = 0;
   int           result_index = 0;

   // Sender pacing and receiver stall control
   bit          idling_on = 1'b1;
   int          burst_left = 0;
   bit          stall_on = 1'b1;
   logic [15:0] stall_pattern = '0;
   int          stall_step = 0;
   int          hold_request = 0;
   int          hold_left = 0;

   vga_scan_out_with_pixel_doubling_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_pixel_color  (req_pixel_color),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pin_byte     (rsp_pin_byte),
      .rsp_active_video (rsp_active_video),
      .rsp_frames_done  (rsp_frames_done)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Work out the pin byte for the current position, then advance the raster
   function automatic scan_out_type raster_step();
      scan_out_type res;
      logic         hs;
      int           sx;
      int           sy;
      res.pin_byte = vsp_pkg::PIN_IDLE;
      res.active_video = 1'b0;
      hs = (col_pos < vsp_pkg::HSYNC_COLS);
      if (line_pos >= vsp_pkg::VISIBLE_LINES) begin
         if (line_pos >= vsp_pkg::VSYNC_FIRST && line_pos <= vsp_pkg::VSYNC_LAST)
            res.pin_byte = hs ? vsp_pkg::PIN_HVSYNC : vsp_pkg::PIN_VSYNC;
         else
            res.pin_byte = hs ? vsp_pkg::PIN_HSYNC : vsp_pkg::PIN_IDLE;
      end else if (hs) begin
         res.pin_byte = vsp_pkg::PIN_HSYNC;
      end else if (col_pos >= vsp_pkg::PICTURE_START &&
                   col_pos < vsp_pkg::PICTURE_START + vsp_pkg::PICTURE_COLS) begin
         // each stored pixel covers two columns; rows are scaled down to the store
         res.active_video = 1'b1;
         sx = (col_pos - vsp_pkg::PICTURE_START) >> 1;
         sy = (line_pos * vsp_pkg::FB_HEIGHT) / vsp_pkg::VISIBLE_LINES;
         if (sy >= vsp_pkg::FB_HEIGHT)
            sy = vsp_pkg::FB_HEIGHT - 1;
         if (sx < vsp_pkg::FB_WIDTH)
            res.pin_byte = vsp_pkg::PIN_IDLE | 8'(fb_model[sy * vsp_pkg::FB_WIDTH + sx]);
      end
      col_pos++;
      if (col_pos >= vsp_pkg::LINE_PIXELS) begin
         col_pos = 0;
         line_pos++;
         if (line_pos >= vsp_pkg::TOTAL_LINES) begin
            line_pos = 0;
            frames_model++;
         end
      end
      res.frames_done = frames_model;
      return res;
   endfunction

   // Store a colour; writes outside the store are dropped
   function automatic void store_pixel(input int x, input int y, input logic [7:0] color);
      logic [7:0] kept;
      kept = color & vsp_pkg::COLOR_MASK;
      if (x < vsp_pkg::FB_WIDTH && y < vsp_pkg::FB_HEIGHT)
         fb_model[y * vsp_pkg::FB_WIDTH + x] = kept[vsp_pkg::COLOR_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH at %0t, result %0d: %s", $time, result_index, msg);
   endtask

   // Offer one item and hold it until its transfer; idle between bursts when idling is on
   task automatic send_item(input logic func, input logic [8:0] px, input logic [7:0] py,
                            input logic [7:0] pc);
      int gap;
      if (idling_on && burst_left <= 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      @(negedge clock);
      req_func = func;
      req_pixel_x = px;
      req_pixel_y = py;
      req_pixel_color = pc;
      req_valid = 1'b1;
      do begin
         @(posedge clock);
      end while (req_stall);
      if (func == vsp_pkg::FUNC_TICK)
         pending_scan_out.push_back(raster_step());
      else
         store_pixel(px, py, pc);
      burst_left--;
   endtask

   task automatic send_tick();
      send_item(vsp_pkg::FUNC_TICK, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
   endtask

   // Write the store pixel that the raster shows a few ticks ahead, if that is in the picture
   task automatic aimed_write(input int ahead);
      int tc;
      int sx;
      int sy;
      tc = col_pos + ahead;
      sx = $urandom_range(0, vsp_pkg::FB_WIDTH - 1);
      sy = $urandom_range(0, vsp_pkg::FB_HEIGHT - 1);
      if (line_pos < vsp_pkg::VISIBLE_LINES) begin
         sy = (line_pos * vsp_pkg::FB_HEIGHT) / vsp_pkg::VISIBLE_LINES;
         if (tc >= vsp_pkg::PICTURE_START &&
             tc < vsp_pkg::PICTURE_START + vsp_pkg::PICTURE_COLS)
            sx = (tc - vsp_pkg::PICTURE_START) >> 1;
      end
      send_item(vsp_pkg::FUNC_WRITE, 9'(sx), 8'(sy), 8'($urandom_range(0, 255)));
   endtask

   // Extremes of the write and tick fields, masking and dropped writes
   task automatic test_write_edges();
      send_item(vsp_pkg::FUNC_WRITE, 9'd0, 8'd0, 8'hFF);
      send_item(vsp_pkg::FUNC_WRITE, 9'(vsp_pkg::FB_WIDTH - 1), 8'(vsp_pkg::FB_HEIGHT - 1),
                8'h2A);
      send_item(vsp_pkg::FUNC_WRITE, 9'(vsp_pkg::FB_WIDTH), 8'd0, 8'h15);
      send_item(vsp_pkg::FUNC_WRITE, 9'd511, 8'd255, 8'hFF);
      send_item(vsp_pkg::FUNC_WRITE, 9'd0, 8'(vsp_pkg::FB_HEIGHT), 8'h3F);
      send_item(vsp_pkg::FUNC_WRITE, 9'd1, 8'd0, 8'hC0);
      send_item(vsp_pkg::FUNC_WRITE, 9'd2, 8'd0, 8'h00);
      send_item(vsp_pkg::FUNC_WRITE, 9'd3, 8'd0, 8'h55);
      send_item(vsp_pkg::FUNC_TICK, 9'd511, 8'd255, 8'hFF);
      send_item(vsp_pkg::FUNC_TICK, 9'd0, 8'd0, 8'h00);
      send_item(vsp_pkg::FUNC_TICK, 9'h155, 8'hAA, 8'h55);
      send_item(vsp_pkg::FUNC_TICK, 9'h0AA, 8'h55, 8'hAA);
   endtask

   // Mixed ticks and writes, most writes landing just ahead of the raster
   task automatic test_random_mix();
      int pick;
      for (int n = 0; n < 500; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 65)
            send_tick();
         else if (pick < 85)
            aimed_write($urandom_range(0, 12));
         else if (pick < 93)
            send_item(vsp_pkg::FUNC_WRITE, 9'($urandom_range(0, vsp_pkg::FB_WIDTH - 1)),
                      8'($urandom_range(0, vsp_pkg::FB_HEIGHT - 1)),
                      8'($urandom_range(0, 255)));
         else
            send_item(vsp_pkg::FUNC_WRITE, 9'($urandom_range(0, 511)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
   endtask

   // Hold off the receiver for a long stretch while items keep coming
   task automatic test_output_hold_off();
      stall_on = 1'b0;
      idling_on = 1'b0;
      hold_request = 300;
      for (int n = 0; n < 40; n++) begin
         if (n % 5 == 4)
            aimed_write($urandom_range(0, 4));
         else
            send_tick();
      end
      stall_on = 1'b1;
      idling_on = 1'b1;
   endtask

   // Receiver stall: long hold when asked, otherwise a rotating random pattern
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else if (hold_request > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_request - 1;
         hold_request = 0;
      end else if (stall_on) begin
         if (stall_step == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = '0;
               1: stall_pattern = 16'($urandom & $urandom);
               default: stall_pattern = 16'($urandom);
            endcase
         end
         rsp_stall = stall_pattern[stall_step];
         stall_step = (stall_step + 1) % 16;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      scan_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_scan_out.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, pin %02h", rsp_pin_byte));
         end else begin
            want = pending_scan_out.pop_front();
            if (rsp_pin_byte !== want.pin_byte)
               report_mismatch($sformatf("pin_byte %02h, expected %02h",
                                         rsp_pin_byte, want.pin_byte));
            if (rsp_active_video !== want.active_video)
               report_mismatch($sformatf("active_video %b, expected %b",
                                         rsp_active_video, want.active_video));
            if (rsp_frames_done !== want.frames_done)
               report_mismatch($sformatf("frames_done %0d, expected %0d",
                                         rsp_frames_done, want.frames_done));
         end
         result_index++;
      end
   end

   initial begin
      foreach (fb_model[i])
         fb_model[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_write_edges();
      test_random_mix();
      test_output_hold_off();

      // drop valid and drain what is still in flight
      @(negedge clock);
      req_valid = 1'b0;
      stall_on = 1'b0;
      while (pending_scan_out.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog: well beyond the clearing pass, the long hold-off and the mixed traffic
   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
